FILE: design/trie_word_insert_lookup_assert.svh
// ----------------------------------------------------------------------------
// Trie word insert/lookup assertion macros
// Concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIE_WORD_INSERT_LOOKUP_ASSERT_SVH
`define TRIE_WORD_INSERT_LOOKUP_ASSERT_SVH

// same-cycle implication, quiet in reset
`define TWIL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet in reset
`define TWIL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// state on the cycle after reset
`define TWIL_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: design/twil_pkg.sv
// ----------------------------------------------------------------------------
// Trie word insert/lookup package
// Shared widths, defaults and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package twil_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int SYM_W         = 8;
  localparam int LIMIT_W       = 9;
  localparam int COUNT_W       = 9;

  localparam logic [LIMIT_W-1:0] NODE_LIMIT_RST = 9'd256;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

`default_nettype wire

FILE: design/twil_cell.sv
// ----------------------------------------------------------------------------
// Trie node cell
// Holds one node (parent, letter, final mark) and one stage of the search
// token chain; a passing token picks up this node on a child match.
// ----------------------------------------------------------------------------
`default_nettype none

module twil_cell
  import twil_pkg::*;
#(
  parameter int INDEX = 1,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tok_in_valid,
  input  wire logic [IDX_W-1:0] tok_in_parent,
  input  wire logic [SYM_W-1:0] tok_in_letter,
  input  wire logic             tok_in_hit,
  input  wire logic [IDX_W-1:0] tok_in_idx,
  input  wire logic             tok_in_fin,
  output logic                  tok_out_valid,
  output logic      [IDX_W-1:0] tok_out_parent,
  output logic      [SYM_W-1:0] tok_out_letter,
  output logic                  tok_out_hit,
  output logic      [IDX_W-1:0] tok_out_idx,
  output logic                  tok_out_fin,
  input  wire logic [CNT_W-1:0] next_free,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [IDX_W-1:0] wr_parent,
  input  wire logic [SYM_W-1:0] wr_letter,
  input  wire logic             mark_en,
  input  wire logic [IDX_W-1:0] mark_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [IDX_W-1:0] parent;
  logic [SYM_W-1:0] letter;
  logic             fin;
  logic             allocated;
  logic             match;

  assign allocated = MY_CNT < next_free;
  assign match = tok_in_valid && !tok_in_hit && allocated &&
                 (parent == tok_in_parent) && (letter == tok_in_letter);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      parent <= wr_parent;
      letter <= wr_letter;
      fin    <= 1'b0;
    end else if (mark_en && (mark_idx == MY_IDX)) begin
      fin <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out_parent <= tok_in_parent;
    tok_out_letter <= tok_in_letter;
    if (match) begin
      tok_out_hit <= 1'b1;
      tok_out_idx <= MY_IDX;
      tok_out_fin <= fin;
    end else begin
      tok_out_hit <= tok_in_hit;
      tok_out_idx <= tok_in_idx;
      tok_out_fin <= tok_in_fin;
    end
  end

endmodule

`default_nettype wire

FILE: design/trie_word_insert_lookup.sv
// A searched symbol's token passes through all MAX_NODES - 1 node cells; on a miss
// the item goes on to allocation, on a hit it does not. An allocation without a
// search and an item with nothing to search do not use the cell chain.
// A word's result is loaded as its last item finishes; a held result stalls it.
// One item in flight at a time. Synchronous reset empties the trie to the
// root alone (a member), sets node_limit to 256 and starts with no word open.
// ----------------------------------------------------------------------------
// Trie word insert/lookup
// Byte-keyed trie dictionary; words arrive at most one symbol per transfer and are
// inserted or looked up through a chain of node cells.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_insert_lookup
  import twil_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] node_limit,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic [SYM_W-1:0]   symbol,
  input  wire logic               has_symbol,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    word_found,
  output logic                    insert_ok,
  output logic      [COUNT_W-1:0] nodes_used
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int NCELL = MAX_NODES - 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TAKE  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]         state;
  logic               in_word;
  logic               word_op;
  logic               still_matching;
  logic               word_failed;
  logic [IDX_W-1:0]   cur;
  logic               cur_fin;
  logic [CNT_W-1:0]   next_free;
  logic [SYM_W-1:0]   sym;
  logic               sym_valid;
  logic               last_item;
  logic [LIMIT_W-1:0] limit;

  logic               tok_valid  [NCELL+1];
  logic [IDX_W-1:0]   tok_parent [NCELL+1];
  logic [SYM_W-1:0]   tok_letter [NCELL+1];
  logic               tok_hit    [NCELL+1];
  logic [IDX_W-1:0]   tok_idx    [NCELL+1];
  logic               tok_fin    [NCELL+1];

  logic               in_xfer;
  logic               slot_free;
  logic               launch;
  logic               can_alloc;
  logic               wr_en;
  logic               mark_en;
  logic               emit;
  logic [CMP_W-1:0]   limit_ext;
  logic [CMP_W-1:0]   lim;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign limit_ext = CMP_W'(limit);
  assign lim       = (limit_ext < CMP_W'(MAX_NODES)) ? limit_ext : CMP_W'(MAX_NODES);
  assign can_alloc = CMP_W'(next_free) < lim;

  assign launch  = (state == ST_TAKE) && sym_valid && !word_failed && still_matching;
  assign wr_en   = (state == ST_ALLOC) && (word_op == OP_INSERT) && can_alloc;
  assign emit    = (state == ST_FIN) && last_item && slot_free;
  assign mark_en = emit && (word_op == OP_INSERT) && !word_failed;

  assign tok_valid[0]  = launch;
  assign tok_parent[0] = cur;
  assign tok_letter[0] = sym;
  assign tok_hit[0]    = 1'b0;
  assign tok_idx[0]    = '0;
  assign tok_fin[0]    = 1'b0;

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    twil_cell #(
      .INDEX (k),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .tok_in_valid   (tok_valid[k-1]),
      .tok_in_parent  (tok_parent[k-1]),
      .tok_in_letter  (tok_letter[k-1]),
      .tok_in_hit     (tok_hit[k-1]),
      .tok_in_idx     (tok_idx[k-1]),
      .tok_in_fin     (tok_fin[k-1]),
      .tok_out_valid  (tok_valid[k]),
      .tok_out_parent (tok_parent[k]),
      .tok_out_letter (tok_letter[k]),
      .tok_out_hit    (tok_hit[k]),
      .tok_out_idx    (tok_idx[k]),
      .tok_out_fin    (tok_fin[k]),
      .next_free      (next_free),
      .wr_en          (wr_en),
      .wr_idx         (next_free[IDX_W-1:0]),
      .wr_parent      (cur),
      .wr_letter      (sym),
      .mark_en        (mark_en),
      .mark_idx       (cur)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= NODE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      limit <= node_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      in_word        <= 1'b0;
      word_op        <= OP_LOOKUP;
      still_matching <= 1'b1;
      word_failed    <= 1'b0;
      next_free      <= CNT_W'(1);
      cur            <= '0;
      cur_fin        <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (!in_word) begin
              word_op        <= operation;
              cur            <= '0;
              cur_fin        <= 1'b1;
              still_matching <= 1'b1;
              word_failed    <= 1'b0;
              in_word        <= 1'b1;
            end
            state <= ST_TAKE;
          end
        end
        ST_TAKE: begin
          if (sym_valid && !word_failed) begin
            state <= still_matching ? ST_WAIT : ST_ALLOC;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_WAIT: begin
          if (tok_valid[NCELL]) begin
            if (tok_hit[NCELL]) begin
              cur     <= tok_idx[NCELL];
              cur_fin <= tok_fin[NCELL];
              state   <= ST_FIN;
            end else begin
              still_matching <= 1'b0;
              state          <= ST_ALLOC;
            end
          end
        end
        ST_ALLOC: begin
          if (wr_en) begin
            cur       <= next_free[IDX_W-1:0];
            cur_fin   <= 1'b0;
            next_free <= next_free + CNT_W'(1);
          end else begin
            word_failed <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_item) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            in_word <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sym       <= symbol;
      sym_valid <= has_symbol;
      last_item <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_found <= (word_op == OP_LOOKUP) && !word_failed && cur_fin;
      insert_ok  <= (word_op == OP_INSERT) && !word_failed;
      nodes_used <= COUNT_W'(next_free);
    end
  end

endmodule

`default_nettype wire

FILE: design/twil_chk.sv
// ----------------------------------------------------------------------------
// Trie word insert/lookup port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trie_word_insert_lookup_assert.svh"

module twil_chk
  import twil_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               word_found,
  input wire logic               insert_ok,
  input wire logic [COUNT_W-1:0] nodes_used
);

  `TWIL_ASSERT_RST(a_reset_state, in_ready && !out_valid, "bad state after reset")

  `TWIL_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transfer taken")

  `TWIL_ASSERT_IMP(a_flags_exclusive, out_valid, !(word_found && insert_ok), "both flags set")

  `TWIL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(word_found) && $stable(insert_ok) &&
                   $stable(nodes_used), "stalled result changed")

endmodule

bind trie_word_insert_lookup twil_chk u_twil_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word_found (word_found),
  .insert_ok  (insert_ok),
  .nodes_used (nodes_used)
);

`default_nettype wire

FILE: sim/trie_word_checker.sv
// ----------------------------------------------------------------------------
// Trie word insert/lookup checker
// Watches the limit, item and result channels, keeps its own copy of the trie
// and compares each result transfer with the oldest predicted word result.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_checker
  import twil_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [LIMIT_W-1:0] node_limit,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               operation,
  input  wire logic [SYM_W-1:0]   symbol,
  input  wire logic               has_symbol,
  input  wire logic               last,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               word_found,
  input  wire logic               insert_ok,
  input  wire logic [COUNT_W-1:0] nodes_used,
  output int                      fail_count,
  output int                      results_due,
  output int                      results_seen
);

  localparam int IDX_W = $clog2(MAX_NODES);

  typedef struct packed {
    logic               found;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } word_result_t;

  word_result_t       word_result_q [$];
  logic [IDX_W-1:0]   up_node    [MAX_NODES];
  logic [SYM_W-1:0]   arc_sym    [MAX_NODES];
  logic               final_mark [MAX_NODES];
  logic [COUNT_W-1:0] free_slot;
  logic [IDX_W-1:0]   here;
  logic               matching;
  logic               failed;
  logic               word_op;
  logic               open_word;
  logic [LIMIT_W-1:0] limit_q;

  function automatic int child_of(logic [IDX_W-1:0] from, logic [SYM_W-1:0] sym);
    for (int i = 1; i < int'(free_slot) && i < MAX_NODES; i++) begin
      if (up_node[i] == from && arc_sym[i] == sym) return i;
    end
    return 0;
  endfunction

  task automatic walk_symbol(logic [SYM_W-1:0] sym);
    int                 kid;
    logic [COUNT_W-1:0] cap;
    if (failed) return;
    if (matching) begin
      kid = child_of(here, sym);
      if (kid != 0) begin
        here = IDX_W'(kid);
        return;
      end
      matching = 1'b0;
    end
    if (word_op == OP_LOOKUP) begin
      failed = 1'b1;
    end else begin
      cap = (limit_q < MAX_NODES) ? limit_q : COUNT_W'(MAX_NODES);
      if (free_slot < cap) begin
        up_node[free_slot[IDX_W-1:0]] = here;
        arc_sym[free_slot[IDX_W-1:0]] = sym;
        here = free_slot[IDX_W-1:0];
        free_slot++;
      end else begin
        failed = 1'b1;
      end
    end
  endtask

  task automatic take_item(logic op, logic [SYM_W-1:0] sym, logic hs, logic lst);
    word_result_t r;
    if (!open_word) begin
      word_op   = op;
      here      = '0;
      matching  = 1'b1;
      failed    = 1'b0;
      open_word = 1'b1;
    end
    if (hs) walk_symbol(sym);
    if (lst) begin
      r.found = (word_op == OP_LOOKUP) && !failed && final_mark[here];
      r.ok    = (word_op == OP_INSERT) && !failed;
      if (r.ok) final_mark[here] = 1'b1;
      r.count = free_slot;
      word_result_q.push_back(r);
      open_word = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    word_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) final_mark[i] = 1'b0;
      final_mark[0] = 1'b1;
      free_slot     = COUNT_W'(1);
      here          = '0;
      matching      = 1'b1;
      failed        = 1'b0;
      word_op       = OP_LOOKUP;
      open_word     = 1'b0;
      limit_q       = NODE_LIMIT_RST;
      word_result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_q = node_limit;
      if (out_valid && out_ready) begin
        results_seen++;
        if (word_result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: found=%0b ok=%0b nodes=%0d",
                     word_found, insert_ok, nodes_used);
        end else begin
          want = word_result_q.pop_front();
          if (want.found !== word_found || want.ok !== insert_ok ||
              want.count !== nodes_used) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result %0d: expected found=%0b ok=%0b nodes=%0d, ",
                        "got found=%0b ok=%0b nodes=%0d"},
                       results_seen, want.found, want.ok, want.count,
                       word_found, insert_ok, nodes_used);
          end
        end
      end
      if (in_valid && in_ready) take_item(operation, symbol, has_symbol, last);
    end
    results_due = word_result_q.size();
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Trie word insert/lookup testbench
// Directed words for the empty word, prefixes, exhausted capacity and a limit
// change inside a word, then random insert and lookup words over a small
// alphabet under a run of node limits, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import twil_pkg::*;

  localparam int SETTLE      = MAX_NODES_DEF + 40;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int PHASE_ITEMS = 170;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] node_limit;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [SYM_W-1:0]   symbol;
  logic               has_symbol;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic               word_found;
  logic               insert_ok;
  logic [COUNT_W-1:0] nodes_used;

  int fail_count;
  int results_due;
  int results_seen;
  int cycles       = 0;
  int items_sent   = 0;
  int limit_writes = 0;
  bit calm         = 1'b0;

  logic [SYM_W-1:0]   pool [3];
  logic [8*SYM_W-1:0] hist_bits [$];
  int                 hist_len  [$];

  always #5 clk = ~clk;

  trie_word_insert_lookup i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .node_limit (node_limit),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .symbol     (symbol),
    .has_symbol (has_symbol),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_found (word_found),
    .insert_ok  (insert_ok),
    .nodes_used (nodes_used)
  );

  trie_word_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .node_limit   (node_limit),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .symbol       (symbol),
    .has_symbol   (has_symbol),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_found   (word_found),
    .insert_ok    (insert_ok),
    .nodes_used   (nodes_used),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(logic op, logic [SYM_W-1:0] sym, logic hs, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation  <= op;
    symbol     <= sym;
    has_symbol <= hs;
    last       <= lst;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    settle();
    repeat (SETTLE) @(negedge clk);
    node_limit <= v;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // symbols packed low byte first; tail closes with a bare marker item
  task automatic send_word(logic op, int len, logic [8*SYM_W-1:0] bits, bit tail);
    for (int k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(0, 11) == 0)
        send_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(k == 0 ? op : logic'($urandom_range(0, 1)), bits[k*SYM_W +: SYM_W],
                1'b1, !tail && k == len - 1);
    end
    if (tail || len == 0)
      send_item(len == 0 ? op : logic'($urandom_range(0, 1)),
                SYM_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [SYM_W-1:0] draw_sym();
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 2)];
    return SYM_W'($urandom_range(1, 255));
  endfunction

  task automatic random_word;
    logic [8*SYM_W-1:0] bits;
    int                 len;
    int                 pick;
    int                 r;
    logic               op;
    r    = $urandom_range(0, 99);
    op   = 1'($urandom_range(0, 1));
    bits = '0;
    if (r < 6) begin
      len = 0;
    end else if (r < 56 && hist_len.size() != 0) begin
      pick = $urandom_range(0, hist_len.size() - 1);
      bits = hist_bits[pick];
      len  = hist_len[pick];
      if ($urandom_range(0, 4) == 0 && len < 8) begin
        bits[len*SYM_W +: SYM_W] = draw_sym();
        len++;
      end else if ($urandom_range(0, 5) == 0) begin
        len--;
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) bits[k*SYM_W +: SYM_W] = draw_sym();
    end
    if (len > 0 && hist_len.size() < 400) begin
      hist_bits.push_back(bits);
      hist_len.push_back(len);
    end
    send_word(op, len, bits, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits [8];
    int                 target;
    logic               hs;
    cfg_valid  = 1'b0;
    node_limit = NODE_LIMIT_RST;
    in_valid   = 1'b0;
    operation  = OP_LOOKUP;
    symbol     = '0;
    has_symbol = 1'b0;
    last       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words
    send_word(OP_LOOKUP, 0, '0, 1'b1);
    send_word(OP_INSERT, 0, '0, 1'b1);
    send_word(OP_LOOKUP, 1, 64'hFF, 1'b0);
    send_word(OP_INSERT, 2, 64'h01FF, 1'b0);
    send_word(OP_LOOKUP, 2, 64'h01FF, 1'b1);
    send_word(OP_LOOKUP, 1, 64'hFF, 1'b0);
    send_word(OP_INSERT, 1, 64'hFF, 1'b0);
    send_word(OP_LOOKUP, 1, 64'hFF, 1'b1);
    send_word(OP_LOOKUP, 3, 64'h0701FF, 1'b0);
    write_limit(9'd3);
    send_word(OP_INSERT, 3, 64'h0701FF, 1'b0);
    // limit raised between two items of one word
    send_item(OP_INSERT, 8'hFF, 1'b1, 1'b0);
    send_item(OP_LOOKUP, 8'h01, 1'b1, 1'b0);
    write_limit(9'd6);
    send_item(OP_LOOKUP, 8'h80, 1'b1, 1'b0);
    send_item(OP_LOOKUP, 8'h40, 1'b1, 1'b1);
    send_word(OP_LOOKUP, 4, 64'h408001FF, 1'b0);
    write_limit(9'd1);
    send_word(OP_INSERT, 1, 64'h03, 1'b0);
    send_word(OP_LOOKUP, 1, 64'hFF, 1'b0);

    limits = '{9'd12, 9'd40, 9'd90, 9'd1, 9'd160, 9'd256, 9'd0, 9'd256};
    limits[6] = LIMIT_W'($urandom_range(1, 256));
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) pool[k] = SYM_W'($urandom_range(1, 255));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 8) begin
          hs = 1'($urandom_range(0, 1));
          send_item(1'($urandom_range(0, 1)),
                    SYM_W'(hs ? $urandom_range(1, 255) : $urandom_range(0, 255)),
                    hs, 1'($urandom_range(0, 1)));
        end else begin
          random_word();
        end
        if ($urandom_range(0, 39) == 0) begin
          settle();
          calm = ($urandom_range(0, 2) == 0);
        end
      end
    end

    settle();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d items and %0d word results under %0d node limit writes",
             items_sent, results_seen, limit_writes);
    $display("words mixed inserts, lookups, empty words, prefixes and full capacity");
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: trie_word_insert_lookup.f
+incdir+design
design/twil_pkg.sv
design/twil_cell.sv
design/trie_word_insert_lookup.sv
design/twil_chk.sv
sim/trie_word_checker.sv
sim/tb_top.sv
